// ===== rtl/core/vnorm_pkg.sv =====
// Shared constants and types for the 3D vector normalisation unit.
// No dependencies; used by every module under rtl/core.
`default_nettype none
package vnorm_pkg;
  localparam int OUT_W     = 32;  // width of each result field
  localparam int THR_W     = 16;  // width of the threshold register
  localparam int UNIT_FRAC = 30;  // fraction bits of a unit component
  localparam int QUO_W     = UNIT_FRAC + 1;  // quotient never exceeds 1.0

  // Pipeline control handed to every stage block.
  typedef struct packed {
    logic adv;  // whole pipeline moves one stage
    logic vld;  // word entering the block is real
  } pipe_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/core/vector3_normalize_unit.sv =====
// Top level of the 3D vector normalisation unit.
// Depends on vnorm_pkg, vnorm_square, vnorm_sqrt and vnorm_div.
`default_nettype none
// The unit takes one vector word per cycle unless the output stalls, and
// returns one result word per vector, in order: three stages form the
// absolute values and the exact sum of squares, one stage per root bit forms
// the floor square root, one stage per quotient bit (31) divides each
// component by the magnitude, and a final register drives the output. The
// pipeline moves as a whole whenever the output register is empty or being
// taken, so a stall at the output holds every stage and loses nothing;
// in_tready follows that condition. Only the low COMP_WIDTH bits of
// each component are used. A magnitude of zero, or one below zero_threshold,
// gives the zero vector with the degenerate flag set; the magnitude is always
// reported. The threshold should be written only while the unit is empty.
module vector3_normalize_unit #(
  parameter int COMP_WIDTH = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [95:0]  in_tdata,   // in_x, in_y, in_z
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [127:0]      out_tdata,  // unit_x, unit_y, unit_z, magnitude
  output logic              out_tuser,  // degenerate
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [15:0]  cfg_data    // zero_threshold
);
  localparam int CW = COMP_WIDTH;
  localparam int OW = vnorm_pkg::OUT_W;
  localparam int QW = vnorm_pkg::QUO_W;

  logic [vnorm_pkg::THR_W-1:0] thr_r;
  logic                        adv;
  vnorm_pkg::pipe_ctl_t        ctl_sq, ctl_rt, ctl_dv;

  logic          sq_vld, rt_vld;
  logic [2*CW-1:0] sum;
  logic [CW-1:0] abs_v [3];
  logic [2:0]    neg_v;
  logic [CW-1:0] root;

  // Component words ride alongside the square root.
  logic [CW-1:0] dly_abs_r [CW][3];
  logic [2:0]    dly_neg_r [CW];

  logic [2:0]    dv_vld, dv_neg;
  logic [QW-1:0] dv_quo [3];
  logic [CW-1:0] dv_mag [3];

  logic [OW-1:0] mag_ext;
  logic          degen;
  logic [OW-1:0] unit_nxt [3];

  logic          out_vld_r;
  logic [127:0]  out_data_r;
  logic          out_user_r;

  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 16'd1;
    end else if (cfg_valid) begin
      thr_r <= cfg_data;
    end
  end

  assign ctl_sq = '{adv: adv, vld: in_tvalid};

  vnorm_square #(.COMP_WIDTH(CW)) u_square (
    .clk(clk), .rst_n(rst_n), .ctl(ctl_sq),
    .x(in_tdata[CW-1:0]), .y(in_tdata[32+CW-1:32]), .z(in_tdata[64+CW-1:64]),
    .vld_o(sq_vld), .sum_o(sum), .abs_o(abs_v), .neg_o(neg_v)
  );

  assign ctl_rt = '{adv: adv, vld: sq_vld};

  vnorm_sqrt #(.COMP_WIDTH(CW)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .ctl(ctl_rt), .rad(sum),
    .vld_o(rt_vld), .root_o(root)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      dly_abs_r[0] <= abs_v;
      dly_neg_r[0] <= neg_v;
      for (int i = 1; i < CW; i++) begin
        dly_abs_r[i] <= dly_abs_r[i-1];
        dly_neg_r[i] <= dly_neg_r[i-1];
      end
    end
  end

  assign ctl_dv = '{adv: adv, vld: rt_vld};

  for (genvar c = 0; c < 3; c++) begin : g_div
    vnorm_div #(.COMP_WIDTH(CW)) u_div (
      .clk(clk), .rst_n(rst_n), .ctl(ctl_dv),
      .a(dly_abs_r[CW-1][c]), .neg(dly_neg_r[CW-1][c]), .m(root),
      .vld_o(dv_vld[c]), .quo_o(dv_quo[c]), .neg_o(dv_neg[c]), .mag_o(dv_mag[c])
    );
  end

  // Final stage: threshold test, sign restore, packing.
  always_comb begin
    mag_ext = OW'(dv_mag[0]);
    degen   = (mag_ext == '0) || (mag_ext < OW'(thr_r));
    for (int c = 0; c < 3; c++) begin
      unit_nxt[c] = OW'(dv_quo[c]);
      if (dv_neg[c]) begin
        unit_nxt[c] = -unit_nxt[c];
      end
      if (degen) begin
        unit_nxt[c] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= dv_vld[0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= {mag_ext, unit_nxt[2], unit_nxt[1], unit_nxt[0]};
      out_user_r <= degen;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[95:0] == '0)
    else $error("degenerate result with non-zero unit vector");

  a_mag_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[127:96] != '0)
    else $error("non-degenerate result with zero magnitude");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |->
      ($signed(out_tdata[31:0]) <= 32'sh4000_0000) &&
      ($signed(out_tdata[31:0]) >= -32'sh4000_0000))
    else $error("unit x component beyond one");
endmodule
`default_nettype wire

// ===== rtl/core/vnorm_square.sv =====
// Absolute values and exact sum of squares, three register stages.
// Depends on vnorm_pkg.
`default_nettype none
module vnorm_square #(
  parameter int COMP_WIDTH = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire vnorm_pkg::pipe_ctl_t      ctl,
  input  wire logic [COMP_WIDTH-1:0]     x,
  input  wire logic [COMP_WIDTH-1:0]     y,
  input  wire logic [COMP_WIDTH-1:0]     z,
  output logic                           vld_o,
  output logic [2*COMP_WIDTH-1:0]        sum_o,
  output logic [COMP_WIDTH-1:0]          abs_o [3],
  output logic [2:0]                     neg_o
);
  localparam int CW = COMP_WIDTH;

  logic [CW-1:0]   abs_nxt [3];
  logic [CW-1:0]   abs_a_r [3];
  logic [CW-1:0]   abs_b_r [3];
  logic [CW-1:0]   abs_c_r [3];
  logic [2:0]      neg_a_r, neg_b_r, neg_c_r;
  logic [2*CW-1:0] sq_r [3];
  logic [2*CW-1:0] sum_r;
  logic [2:0]      vld_r;

  always_comb begin
    abs_nxt[0] = x[CW-1] ? -x : x;
    abs_nxt[1] = y[CW-1] ? -y : y;
    abs_nxt[2] = z[CW-1] ? -z : z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.adv) begin
      vld_r <= {vld_r[1:0], ctl.vld};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      for (int i = 0; i < 3; i++) begin
        abs_a_r[i] <= abs_nxt[i];
        sq_r[i]    <= abs_a_r[i] * abs_a_r[i];
        abs_b_r[i] <= abs_a_r[i];
        abs_c_r[i] <= abs_b_r[i];
      end
      neg_a_r <= {z[CW-1], y[CW-1], x[CW-1]};
      neg_b_r <= neg_a_r;
      neg_c_r <= neg_b_r;
      sum_r   <= sq_r[0] + sq_r[1] + sq_r[2];
    end
  end

  assign vld_o = vld_r[2];
  assign sum_o = sum_r;
  assign abs_o = abs_c_r;
  assign neg_o = neg_c_r;
endmodule
`default_nettype wire

// ===== rtl/core/vnorm_sqrt.sv =====
// Pipelined floor square root, two radicand bits per register stage.
// Depends on vnorm_pkg.
`default_nettype none
module vnorm_sqrt #(
  parameter int COMP_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire vnorm_pkg::pipe_ctl_t  ctl,
  input  wire logic [2*COMP_WIDTH-1:0] rad,
  output logic                       vld_o,
  output logic [COMP_WIDTH-1:0]      root_o
);
  localparam int CW = COMP_WIDTH;
  localparam int SW = 2 * CW;
  localparam int RW = CW + 3;

  logic [SW-1:0] p_rad  [CW+1];
  logic [RW-1:0] p_rem  [CW+1];
  logic [CW-1:0] p_root [CW+1];
  logic [CW:0]   p_vld;

  assign p_rad[0]  = rad;
  assign p_rem[0]  = '0;
  assign p_root[0] = '0;
  assign p_vld[0]  = ctl.vld;

  for (genvar i = 0; i < CW; i++) begin : g_stage
    logic [RW-1:0] rem_sh, trial, rem_nxt, rem_r;
    logic [CW-1:0] root_nxt, root_r;
    logic [SW-1:0] rad_r;
    logic          ge, vld_r;

    always_comb begin
      rem_sh   = {p_rem[i][RW-3:0], p_rad[i][SW-1:SW-2]};
      trial    = {1'b0, p_root[i], 2'b01};
      ge       = (rem_sh >= trial);
      rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
      root_nxt = {p_root[i][CW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (ctl.adv) begin
        vld_r <= p_vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.adv) begin
        rem_r  <= rem_nxt;
        root_r <= root_nxt;
        rad_r  <= {p_rad[i][SW-3:0], 2'b00};
      end
    end

    assign p_rad[i+1]  = rad_r;
    assign p_rem[i+1]  = rem_r;
    assign p_root[i+1] = root_r;
    assign p_vld[i+1]  = vld_r;
  end

  assign vld_o  = p_vld[CW];
  assign root_o = p_root[CW];
endmodule
`default_nettype wire

// ===== rtl/core/vnorm_div.sv =====
// Pipelined restoring divider: (a << 30) / m, one quotient bit per stage.
// Depends on vnorm_pkg.
`default_nettype none
module vnorm_div #(
  parameter int COMP_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire vnorm_pkg::pipe_ctl_t  ctl,
  input  wire logic [COMP_WIDTH-1:0] a,
  input  wire logic                  neg,
  input  wire logic [COMP_WIDTH-1:0] m,
  output logic                       vld_o,
  output logic [vnorm_pkg::QUO_W-1:0] quo_o,
  output logic                       neg_o,
  output logic [COMP_WIDTH-1:0]      mag_o
);
  localparam int CW = COMP_WIDTH;
  localparam int QW = vnorm_pkg::QUO_W;
  localparam int DW = CW + vnorm_pkg::UNIT_FRAC;

  logic [DW-1:0] dvd;
  logic [CW-1:0] p_rem [QW+1];
  logic [QW-1:0] p_low [QW+1];
  logic [CW-1:0] p_mag [QW+1];
  logic [QW:0]   p_neg, p_vld;

  // The quotient fits in QW bits, so the top of the dividend is already
  // below the divisor and serves as the first partial remainder.
  assign dvd      = {a, {vnorm_pkg::UNIT_FRAC{1'b0}}};
  assign p_rem[0] = {1'b0, dvd[DW-1:QW]};
  assign p_low[0] = dvd[QW-1:0];
  assign p_mag[0] = m;
  assign p_neg[0] = neg;
  assign p_vld[0] = ctl.vld;

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [CW:0]   rs, rs_sub;
    logic          ge, vld_r, neg_r;
    logic [CW-1:0] rem_r, mag_r;
    logic [QW-1:0] low_r;

    always_comb begin
      rs     = {p_rem[i], p_low[i][QW-1]};
      ge     = (rs >= {1'b0, p_mag[i]});
      rs_sub = rs - {1'b0, p_mag[i]};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (ctl.adv) begin
        vld_r <= p_vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.adv) begin
        rem_r <= ge ? rs_sub[CW-1:0] : rs[CW-1:0];
        low_r <= {p_low[i][QW-2:0], ge};
        mag_r <= p_mag[i];
        neg_r <= p_neg[i];
      end
    end

    assign p_rem[i+1] = rem_r;
    assign p_low[i+1] = low_r;
    assign p_mag[i+1] = mag_r;
    assign p_neg[i+1] = neg_r;
    assign p_vld[i+1] = vld_r;
  end

  assign vld_o = p_vld[QW];
  assign quo_o = p_low[QW];
  assign neg_o = p_neg[QW];
  assign mag_o = p_mag[QW];
endmodule
`default_nettype wire

// ===== tb/tb_vector3_normalize_unit.sv =====
// Testbench for the 3D vector normalisation unit: drives vector words, predicts
// each result word and compares it field by field. Depends on vnorm_pkg and the RTL.
`timescale 1ns / 1ps
module tb_vector3_normalize_unit;

  localparam int COMP_W    = 32;
  localparam int LATENCY   = COMP_W + 35;
  localparam int STALL_MAX = 5000;

  typedef struct {
    logic [31:0] ux, uy, uz, mag;
    logic        degen;
  } norm_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [95:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;

  vector3_normalize_unit #(.COMP_WIDTH(COMP_W)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Model copy of the threshold register and the queue of pending results.
  logic [vnorm_pkg::THR_W-1:0] threshold_q = 16'd1;
  norm_result_t     pending_norms[$];
  int unsigned      error_count = 0;
  int unsigned      send_idle_pct = 0;
  int unsigned      recv_idle_pct = 0;
  bit               hold_output = 1'b0;
  int unsigned      quiet_cycles = 0;

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Signed quotient of one component by the magnitude, in Q2.30.
  function automatic logic [31:0] unit_component(input logic [63:0] a, input bit neg,
                                                 input logic [63:0] m);
    logic [63:0] q;
    q = (a << vnorm_pkg::UNIT_FRAC) / m;
    if (neg) q = 64'd0 - q;
    return q[31:0];
  endfunction

  function automatic norm_result_t normalise(input logic [95:0] v);
    norm_result_t r;
    logic [63:0] a[3];
    bit          n[3];
    logic [63:0] sum, m;
    for (int i = 0; i < 3; i++) begin
      n[i] = v[32*i+31];
      a[i] = n[i] ? (64'd1 << 32) - {32'd0, v[32*i +: 32]} : {32'd0, v[32*i +: 32]};
    end
    sum = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
    m = floor_sqrt(sum);
    r.mag = m[31:0];
    if (m == 0 || m < {48'd0, threshold_q}) begin
      r.ux = 0; r.uy = 0; r.uz = 0; r.degen = 1'b1;
    end else begin
      r.ux = unit_component(a[0], n[0], m);
      r.uy = unit_component(a[1], n[1], m);
      r.uz = unit_component(a[2], n[2], m);
      r.degen = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    error_count++;
  endtask

  // Input side: one word per call, random idle cycles ahead of it. The valid
  // line stays high between words sent back to back.
  task automatic send_vector(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {z, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_norms.push_back(normalise({z, y, x}));
  endtask

  task automatic write_threshold(input logic [15:0] t);
    cfg_valid <= 1'b1;
    cfg_data  <= t;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    threshold_q = t;
  endtask

  // Sender stops and waits for every expected result.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_norms.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // Output side: random backpressure, or a long hold when asked.
  always @(posedge clk) begin
    out_tready <= !hold_output && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    norm_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_norms.size() == 0) begin
        report_mismatch("unexpected word", out_tdata[31:0], 32'd0);
      end else begin
        want = pending_norms.pop_front();
        if (out_tdata[31:0] !== want.ux)    report_mismatch("unit_x", out_tdata[31:0], want.ux);
        if (out_tdata[63:32] !== want.uy)   report_mismatch("unit_y", out_tdata[63:32], want.uy);
        if (out_tdata[95:64] !== want.uz)   report_mismatch("unit_z", out_tdata[95:64], want.uz);
        if (out_tdata[127:96] !== want.mag)
          report_mismatch("magnitude", out_tdata[127:96], want.mag);
        if (out_tuser !== want.degen)
          report_mismatch("degenerate", {31'd0, out_tuser}, {31'd0, want.degen});
      end
    end
  end

  // Watchdog: a long run with no word moving on any channel ends the test.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 4 * (STALL_MAX + LATENCY) + 200) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] random_component();
    case ($urandom_range(5))
      0: return $urandom_range(3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
      1: return $urandom_range(15) - 8;            // tiny, near-degenerate
      2: return $urandom_range(262143) - 131072;   // about +-2.0
      default: return $urandom;
    endcase
  endfunction

  task automatic test_extremes();
    send_vector(0, 0, 0);
    send_vector(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vector(32'h8000_0000, 0, 0);
    send_vector(0, 32'h7fff_ffff, 0);
    send_vector(0, 0, 32'hffff_ffff);
    send_vector(32'h0001_0000, 0, 0);
    send_vector(0, 32'hffff_0000, 0);
    send_vector(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_vector(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f);
    send_vector(1, 0, 0);
    wait_drained();
  endtask

  // Threshold at its extremes and at 0x0100, with magnitudes either side of it.
  task automatic test_threshold();
    write_threshold(16'd0);
    send_vector(0, 0, 0);
    send_vector(1, 0, 0);
    wait_drained();
    write_threshold(16'hffff);
    send_vector(32'h0000_fffe, 0, 0);
    send_vector(32'h0000_ffff, 0, 0);
    send_vector(0, 32'hffff_0001, 0);
    send_vector(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
    wait_drained();
    write_threshold(16'h0100);
    send_vector(32'h0000_00ff, 0, 0);
    send_vector(32'h0000_0100, 0, 0);
    wait_drained();
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++)
      send_vector(random_component(), random_component(), random_component());
  endtask

  // Output held off long enough for the pipeline to fill and block its input.
  task automatic test_backpressure();
    fork
      begin
        hold_output = 1'b1;
        repeat (LATENCY * 3) @(posedge clk);
        hold_output = 1'b0;
      end
      test_random(100);
    join
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_threshold();
    write_threshold(16'd1);
    send_idle_pct = 25; recv_idle_pct = 84;
    test_random(130);
    wait_drained();
    write_threshold(16'($urandom_range(65535)));
    send_idle_pct = 84; recv_idle_pct = 25;
    test_random(130);
    wait_drained();
    write_threshold(16'($urandom_range(255)));
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(100);
    test_backpressure();
    if (error_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule
